// ===== sv/tcw_pkg.sv =====
// Shared types, codes and the microcode table of the text console character writer.
package tcw_pkg;

    // Request codes.
    localparam logic [1:0] RQ_PUT   = 2'd0;
    localparam logic [1:0] RQ_READ  = 2'd1;
    localparam logic [1:0] RQ_CLEAR = 2'd2;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Register indexes on the configuration port.
    localparam logic REG_FORE = 1'b0;
    localparam logic REG_BACK = 1'b1;

    // Microcode address.
    typedef logic [4:0] upc_t;

    localparam upc_t U_IDLE    = 5'd0;
    localparam upc_t U_DONE    = 5'd1;
    localparam upc_t U_RST     = 5'd2;
    localparam upc_t U_ZFILL_R = 5'd3;
    localparam upc_t U_CLEAR   = 5'd4;
    localparam upc_t U_BFILL   = 5'd5;
    localparam upc_t U_READ    = 5'd6;
    localparam upc_t U_NEWLINE = 5'd7;
    localparam upc_t U_CR      = 5'd8;
    localparam upc_t U_BACK    = 5'd9;
    localparam upc_t U_BACK2   = 5'd10;
    localparam upc_t U_BACK3   = 5'd11;
    localparam upc_t U_TAB     = 5'd12;
    localparam upc_t U_PUT     = 5'd13;
    localparam upc_t U_STORE_B = 5'd14;
    localparam upc_t U_SETTLE  = 5'd15;
    localparam upc_t U_CONT    = 5'd16;
    localparam upc_t U_TABNEXT = 5'd17;
    localparam upc_t U_SCROLL  = 5'd18;
    localparam upc_t U_SC_RD   = 5'd19;
    localparam upc_t U_SC_WR   = 5'd20;
    localparam upc_t U_SC_ZERO = 5'd21;
    localparam upc_t U_SC_END  = 5'd22;

    // Memory operations.
    typedef logic [2:0] mem_op_t;

    localparam mem_op_t M_NONE         = 3'd0;
    localparam mem_op_t M_WR_CUR_CHR   = 3'd1;
    localparam mem_op_t M_WR_CUR_BLANK = 3'd2;
    localparam mem_op_t M_WR_IDX_ZERO  = 3'd3;
    localparam mem_op_t M_WR_IDX_BLANK = 3'd4;
    localparam mem_op_t M_WR_IDX_COPY  = 3'd5;
    localparam mem_op_t M_RD_REQ       = 3'd6;
    localparam mem_op_t M_RD_COPY      = 3'd7;

    // Cursor operations.
    typedef logic [2:0] cur_op_t;

    localparam cur_op_t CUR_NONE    = 3'd0;
    localparam cur_op_t CUR_COL_INC = 3'd1;
    localparam cur_op_t CUR_NEWLINE = 3'd2;
    localparam cur_op_t CUR_CR      = 3'd3;
    localparam cur_op_t CUR_BACK    = 3'd4;
    localparam cur_op_t CUR_HOME    = 3'd5;
    localparam cur_op_t CUR_ROW_DEC = 3'd6;

    // Sweep index operations.
    typedef logic [1:0] idx_op_t;

    localparam idx_op_t IDX_HOLD = 2'd0;
    localparam idx_op_t IDX_CLR  = 2'd1;
    localparam idx_op_t IDX_INC  = 2'd2;

    // Tab counter operations.
    typedef logic [1:0] cnt_op_t;

    localparam cnt_op_t CNT_HOLD = 2'd0;
    localparam cnt_op_t CNT_LOAD = 2'd1;
    localparam cnt_op_t CNT_DEC  = 2'd2;

    // Jump conditions.
    typedef logic [3:0] cond_t;

    localparam cond_t J_NEVER     = 4'd0;
    localparam cond_t J_ALWAYS    = 4'd1;
    localparam cond_t J_DISPATCH  = 4'd2;
    localparam cond_t J_OUT_FREE  = 4'd3;
    localparam cond_t J_IDX_END   = 4'd4;
    localparam cond_t J_COPY_MORE = 4'd5;
    localparam cond_t J_ROW_OVER  = 4'd6;
    localparam cond_t J_TAB_ZERO  = 4'd7;
    localparam cond_t J_AT_HOME   = 4'd8;

    // Tab writes this many further spaces after the first one.
    localparam logic [1:0] TAB_EXTRA = 2'd3;

    // One control word of the microprogram.
    typedef struct packed {
        mem_op_t mem_op;
        cur_op_t cur_op;
        idx_op_t idx_op;
        cnt_op_t cnt_op;
        cond_t   cond;
        logic    hold;
        logic    done;
        upc_t    target;
    } ctl_t;

    // Conditions reported by the datapath.
    typedef struct packed {
        logic out_free;
        logic idx_end;
        logic copy_more;
        logic row_over;
        logic tab_zero;
        logic at_home;
    } stat_t;

    function automatic ctl_t uword(mem_op_t m, cur_op_t c, idx_op_t i, cnt_op_t n,
                                   cond_t j, logic h, logic d, upc_t t);
        ctl_t w;
        w.mem_op = m;
        w.cur_op = c;
        w.idx_op = i;
        w.cnt_op = n;
        w.cond   = j;
        w.hold   = h;
        w.done   = d;
        w.target = t;
        return w;
    endfunction

    // The microprogram. A step jumps to its target (for a dispatch step, the entry that
    // dispatch gives) when its condition holds; otherwise it stays put when hold is set, or else falls through.
    function automatic ctl_t ucode_rom(upc_t a);
        ctl_t w;
        case (a)
            U_IDLE:    w = uword(M_NONE, CUR_NONE, IDX_HOLD, CNT_HOLD,
                                 J_DISPATCH, 1'b1, 1'b0, U_IDLE);
            U_DONE:    w = uword(M_NONE, CUR_NONE, IDX_HOLD, CNT_HOLD,
                                 J_OUT_FREE, 1'b1, 1'b1, U_IDLE);
            U_RST:     w = uword(M_NONE, CUR_NONE, IDX_CLR, CNT_HOLD,
                                 J_NEVER, 1'b0, 1'b0, U_IDLE);
            U_ZFILL_R: w = uword(M_WR_IDX_ZERO, CUR_NONE, IDX_INC, CNT_HOLD,
                                 J_IDX_END, 1'b1, 1'b0, U_IDLE);
            U_CLEAR:   w = uword(M_NONE, CUR_HOME, IDX_CLR, CNT_HOLD,
                                 J_NEVER, 1'b0, 1'b0, U_IDLE);
            U_BFILL:   w = uword(M_WR_IDX_BLANK, CUR_NONE, IDX_INC, CNT_HOLD,
                                 J_IDX_END, 1'b1, 1'b0, U_DONE);
            U_READ:    w = uword(M_RD_REQ, CUR_NONE, IDX_HOLD, CNT_HOLD,
                                 J_ALWAYS, 1'b0, 1'b0, U_DONE);
            U_NEWLINE: w = uword(M_NONE, CUR_NEWLINE, IDX_HOLD, CNT_HOLD,
                                 J_ALWAYS, 1'b0, 1'b0, U_SETTLE);
            U_CR:      w = uword(M_NONE, CUR_CR, IDX_HOLD, CNT_HOLD,
                                 J_ALWAYS, 1'b0, 1'b0, U_DONE);
            U_BACK:    w = uword(M_NONE, CUR_NONE, IDX_HOLD, CNT_HOLD,
                                 J_AT_HOME, 1'b0, 1'b0, U_DONE);
            U_BACK2:   w = uword(M_NONE, CUR_BACK, IDX_HOLD, CNT_HOLD,
                                 J_NEVER, 1'b0, 1'b0, U_IDLE);
            U_BACK3:   w = uword(M_WR_CUR_BLANK, CUR_NONE, IDX_HOLD, CNT_HOLD,
                                 J_ALWAYS, 1'b0, 1'b0, U_DONE);
            U_TAB:     w = uword(M_NONE, CUR_NONE, IDX_HOLD, CNT_LOAD,
                                 J_ALWAYS, 1'b0, 1'b0, U_STORE_B);
            U_PUT:     w = uword(M_WR_CUR_CHR, CUR_COL_INC, IDX_HOLD, CNT_HOLD,
                                 J_ALWAYS, 1'b0, 1'b0, U_SETTLE);
            U_STORE_B: w = uword(M_WR_CUR_BLANK, CUR_COL_INC, IDX_HOLD, CNT_HOLD,
                                 J_NEVER, 1'b0, 1'b0, U_IDLE);
            U_SETTLE:  w = uword(M_NONE, CUR_NONE, IDX_HOLD, CNT_HOLD,
                                 J_ROW_OVER, 1'b0, 1'b0, U_SCROLL);
            U_CONT:    w = uword(M_NONE, CUR_NONE, IDX_HOLD, CNT_HOLD,
                                 J_TAB_ZERO, 1'b0, 1'b0, U_DONE);
            U_TABNEXT: w = uword(M_NONE, CUR_NONE, IDX_HOLD, CNT_DEC,
                                 J_ALWAYS, 1'b0, 1'b0, U_STORE_B);
            U_SCROLL:  w = uword(M_NONE, CUR_NONE, IDX_CLR, CNT_HOLD,
                                 J_NEVER, 1'b0, 1'b0, U_IDLE);
            U_SC_RD:   w = uword(M_RD_COPY, CUR_NONE, IDX_HOLD, CNT_HOLD,
                                 J_NEVER, 1'b0, 1'b0, U_IDLE);
            U_SC_WR:   w = uword(M_WR_IDX_COPY, CUR_NONE, IDX_INC, CNT_HOLD,
                                 J_COPY_MORE, 1'b0, 1'b0, U_SC_RD);
            U_SC_ZERO: w = uword(M_WR_IDX_ZERO, CUR_NONE, IDX_INC, CNT_HOLD,
                                 J_IDX_END, 1'b1, 1'b0, U_SC_END);
            U_SC_END:  w = uword(M_NONE, CUR_ROW_DEC, IDX_HOLD, CNT_HOLD,
                                 J_ALWAYS, 1'b0, 1'b0, U_CONT);
            default:   w = uword(M_NONE, CUR_NONE, IDX_HOLD, CNT_HOLD,
                                 J_ALWAYS, 1'b0, 1'b0, U_IDLE);
        endcase
        return w;
    endfunction

    // Entry point of the routine that serves a newly accepted request.
    function automatic upc_t dispatch(logic [1:0] req, logic [7:0] ch);
        upc_t t;
        case (req)
            RQ_PUT:
            begin
                case (ch)
                    CH_NUL:  t = U_DONE;
                    CH_LF:   t = U_NEWLINE;
                    CH_TAB:  t = U_TAB;
                    CH_CR:   t = U_CR;
                    CH_BS:   t = U_BACK;
                    default: t = U_PUT;
                endcase
            end
            RQ_READ:  t = U_READ;
            RQ_CLEAR: t = U_CLEAR;
            default:  t = U_DONE;
        endcase
        return t;
    endfunction

endpackage

// ===== sv/tcw_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
module tcw_seq
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_accept,
    input  logic [1:0] req_type,
    input  logic [7:0] char_code,
    input  stat_t      stat,
    output ctl_t       ctl,
    output logic       idle
);

    upc_t upc_reg;
    upc_t upc_next;
    logic take;

    // Current control word.
    assign ctl  = ucode_rom(upc_reg);
    assign idle = (upc_reg == U_IDLE);

    // Jump condition.
    always_comb
    begin
        case (ctl.cond)
            J_NEVER:     take = 1'b0;
            J_ALWAYS:    take = 1'b1;
            J_DISPATCH:  take = in_accept;
            J_OUT_FREE:  take = stat.out_free;
            J_IDX_END:   take = stat.idx_end;
            J_COPY_MORE: take = stat.copy_more;
            J_ROW_OVER:  take = stat.row_over;
            J_TAB_ZERO:  take = stat.tab_zero;
            J_AT_HOME:   take = stat.at_home;
            default:     take = 1'b0;
        endcase
    end

    // Next step.
    always_comb
    begin
        if (take)
        begin
            if (ctl.cond == J_DISPATCH)
            begin
                upc_next = dispatch(req_type, char_code);
            end
            else
            begin
                upc_next = ctl.target;
            end
        end
        else if (ctl.hold)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_reg + 5'd1;
        end
    end

    // Step counter; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_RST;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== sv/tcw_dp.sv =====
// Datapath: cursor, sweep index, tab counter, screen memory and result register.
module tcw_dp
    import tcw_pkg::*;
#(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    output stat_t       stat,
    input  logic        in_accept,
    input  logic [1:0]  req_type,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_address,
    input  logic [3:0]  fore_color,
    input  logic [3:0]  back_color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic [15:0] cell_value
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CW    = $clog2(COLUMNS + 1);

    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_A    = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS - 1);
    localparam logic [RW-1:0] ROWS_R    = RW'(ROWS);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

    logic [15:0] mem [CELLS];

    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic [1:0]    req_reg;
    logic [7:0]    chr_reg;
    logic [10:0]   addr_reg;
    logic [15:0]   rd_data_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [4:0]    cursor_row_reg;
    logic [6:0]    cursor_col_reg;
    logic [15:0]   cell_value_reg;

    logic [AW-1:0] cur_addr;
    logic [7:0]    attr;
    logic          we;
    logic [AW-1:0] wa;
    logic [15:0]   wd;
    logic          re;
    logic [AW-1:0] ra;
    logic          read_hit;
    logic          out_load;

    assign attr     = {back_color, fore_color};
    assign cur_addr = AW'(row_reg) * COLS_A + AW'(col_reg);

    // Conditions for the sequencer.
    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.idx_end   = (idx_reg == LAST_A);
    assign stat.copy_more = (idx_reg != COPY_LAST);
    assign stat.row_over  = (row_reg == ROWS_R);
    assign stat.tab_zero  = (cnt_reg == 2'd0);
    assign stat.at_home   = (row_reg == '0) && (col_reg == '0);

    // Cursor update.
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        case (ctl.cur_op)
            CUR_NONE:
            begin
                row_next = row_reg;
            end
            CUR_COL_INC:
            begin
                if (col_reg == LAST_COL)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            CUR_NEWLINE:
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            CUR_CR:
            begin
                col_next = '0;
            end
            CUR_BACK:
            begin
                if (col_reg == '0)
                begin
                    col_next = LAST_COL;
                    row_next = row_reg - 1'b1;
                end
                else
                begin
                    col_next = col_reg - 1'b1;
                end
            end
            CUR_HOME:
            begin
                col_next = '0;
                row_next = '0;
            end
            CUR_ROW_DEC:
            begin
                row_next = row_reg - 1'b1;
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    // Sweep index and tab counter.
    always_comb
    begin
        case (ctl.idx_op)
            IDX_CLR: idx_next = '0;
            IDX_INC: idx_next = idx_reg + 1'b1;
            default: idx_next = idx_reg;
        endcase

        if (in_accept)
        begin
            cnt_next = 2'd0;
        end
        else
        begin
            case (ctl.cnt_op)
                CNT_LOAD: cnt_next = TAB_EXTRA;
                CNT_DEC:  cnt_next = cnt_reg - 2'd1;
                default:  cnt_next = cnt_reg;
            endcase
        end
    end

    // Memory port control.
    always_comb
    begin
        we = 1'b0;
        wa = idx_reg;
        wd = 16'h0000;
        re = 1'b0;
        ra = idx_reg + COLS_A;
        case (ctl.mem_op)
            M_WR_CUR_CHR:
            begin
                we = 1'b1;
                wa = cur_addr;
                wd = {attr, chr_reg};
            end
            M_WR_CUR_BLANK:
            begin
                we = 1'b1;
                wa = cur_addr;
                wd = {attr, CH_SPACE};
            end
            M_WR_IDX_ZERO:
            begin
                we = 1'b1;
            end
            M_WR_IDX_BLANK:
            begin
                we = 1'b1;
                wd = {attr, CH_SPACE};
            end
            M_WR_IDX_COPY:
            begin
                we = 1'b1;
                wd = rd_data_reg;
            end
            M_RD_REQ:
            begin
                re = 1'b1;
                ra = AW'(addr_reg);
            end
            M_RD_COPY:
            begin
                re = 1'b1;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // Screen memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg  <= req_type;
            chr_reg  <= char_code;
            addr_reg <= cell_address;
        end
    end

    // Cursor, index and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    // Result register: loaded when the done step finds it free.
    assign read_hit = (req_reg == RQ_READ) && (32'(addr_reg) < CELLS);
    assign out_load = ctl.done && stat.out_free;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cursor_row_reg <= 5'(row_reg);
            cursor_col_reg <= 7'(col_reg);
            cell_value_reg <= read_hit ? rd_data_reg : 16'h0000;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_row = cursor_row_reg;
    assign cursor_col = cursor_col_reg;
    assign cell_value = cell_value_reg;

endmodule

// ===== sv/text_console_char_writer.sv =====
// Top level of the text console character writer: register port, sequencer and datapath.
//
//  Channel  Direction  Handshake                Payload
//  in       inbound    in_valid / in_stall      req_type, char_code, cell_address
//  out      outbound   out_valid / out_stall    cursor_row, cursor_col, cell_value
//  config   inbound    psel/penable/pwrite      paddr, pwdata, prdata (colours)
//
// One request at a time. A scroll adds a sweep of the screen memory that copies each
// row up by one row in alternating read and write steps, then zeroes the last row.
// After reset a clearing pass zeroes the screen with in_stall held high;
// configuration writes are taken throughout.
// A stalled result holds in the output register; the next request is taken
// once the result has been loaded into it.
module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic [15:0] cell_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0] fore_color_reg;
    logic [3:0] fore_color_next;
    logic [3:0] back_color_reg;
    logic [3:0] back_color_next;
    logic       cfg_write;
    logic       idle;
    logic       in_accept;
    ctl_t       ctl;
    stat_t      stat;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        fore_color_next = fore_color_reg;
        back_color_next = back_color_reg;
        if (cfg_write)
        begin
            if (paddr[2] == REG_FORE)
            begin
                fore_color_next = pwdata[3:0];
            end
            else
            begin
                back_color_next = pwdata[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_color_reg <= 4'd7;
            back_color_reg <= 4'd0;
        end
        else
        begin
            fore_color_reg <= fore_color_next;
            back_color_reg <= back_color_next;
        end
    end

    assign prdata = (paddr[2] == REG_BACK) ? {28'd0, back_color_reg}
                                           : {28'd0, fore_color_reg};

    // Input transfer is taken only while the sequencer waits for work.
    assign in_stall  = !idle;
    assign in_accept = in_valid && idle;

    tcw_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .req_type  (req_type),
        .char_code (char_code),
        .stat      (stat),
        .ctl       (ctl),
        .idle      (idle)
    );

    tcw_dp #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .in_accept    (in_accept),
        .req_type     (req_type),
        .char_code    (char_code),
        .cell_address (cell_address),
        .fore_color   (fore_color_reg),
        .back_color   (back_color_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .cell_value   (cell_value)
    );

endmodule

// ===== sv/tcw_check.sv =====
// Port-level checker for the text console character writer, with its bind.
module tcw_check #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  cursor_row,
    input logic [6:0]  cursor_col,
    input logic [15:0] cell_value
);

    // A result waiting on a stall stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable(cursor_row) && $stable(cursor_col) && $stable(cell_value))
        else $error("result payload changed while stalled");

    // One request at a time: after a transfer in, the input stalls.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken before the first was served");

    // The reported cursor always lies on the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(cursor_row) < ROWS) && (32'(cursor_col) < COLUMNS))
        else $error("cursor reported off the screen");

endmodule

bind text_console_char_writer tcw_check #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
) u_tcw_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .cell_value (cell_value)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the text console character writer: directed and random requests.
module testbench;
    import tcw_pkg::*;

    localparam int ROWS    = 25;
    localparam int COLUMNS = 80;
    localparam int CELLS   = ROWS * COLUMNS;

    // Request code that the block leaves unused.
    localparam logic [1:0] RQ_UNUSED = 2'd3;

    localparam int ITEMS_PER_PHASE = 75;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_AT     = 150;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [4:0]  row;
        logic [6:0]  col;
        logic [15:0] cell_data;
    } console_result_t;

    // Mirror of the screen and cursor, and the results still awaited from the block.
    class console_scoreboard;
        logic [15:0]     screen [CELLS];
        int unsigned     row;
        int unsigned     col;
        logic [3:0]      fore;
        logic [3:0]      back;
        console_result_t awaited [$];
        int              failures;

        function new();
            foreach (screen[i])
                screen[i] = 16'h0000;
            row      = 0;
            col      = 0;
            fore     = 4'd7;
            back     = 4'd0;
            failures = 0;
        endfunction

        function void set_colour(logic idx, logic [31:0] value);
            if (idx == REG_FORE)
                fore = value[3:0];
            else
                back = value[3:0];
        endfunction

        function logic [15:0] attribute();
            return {back, fore, 8'h00};
        endfunction

        // Wrap the column, then scroll while the cursor is below the last row.
        function void settle();
            if (col >= COLUMNS)
            begin
                col = 0;
                row++;
            end
            while (row >= ROWS)
            begin
                for (int i = 0; i < CELLS - COLUMNS; i++)
                    screen[i] = screen[i + COLUMNS];
                for (int i = CELLS - COLUMNS; i < CELLS; i++)
                    screen[i] = 16'h0000;
                row--;
            end
        endfunction

        function void store(logic [7:0] ch);
            screen[row * COLUMNS + col] = attribute() | {8'h00, ch};
            col++;
            settle();
        endfunction

        // Apply one accepted request and queue the result it should give.
        function void note_request(logic [1:0] req, logic [7:0] ch, logic [10:0] addr);
            console_result_t r;
            r.cell_data = 16'h0000;
            case (req)
                RQ_PUT:
                begin
                    case (ch)
                        CH_NUL:
                            ;
                        CH_LF:
                        begin
                            col = 0;
                            row++;
                            settle();
                        end
                        CH_TAB:
                            repeat (4) store(CH_SPACE);
                        CH_CR:
                            col = 0;
                        CH_BS:
                        begin
                            // Backspace at home leaves everything as it is.
                            if (!(row == 0 && col == 0))
                            begin
                                if (col == 0)
                                begin
                                    row--;
                                    col = COLUMNS - 1;
                                end
                                else
                                    col--;
                                screen[row * COLUMNS + col] = attribute() | {8'h00, CH_SPACE};
                            end
                        end
                        default:
                            store(ch);
                    endcase
                end
                RQ_READ:
                begin
                    if (int'(addr) < CELLS)
                        r.cell_data = screen[addr];
                end
                RQ_CLEAR:
                begin
                    foreach (screen[i])
                        screen[i] = attribute() | {8'h00, CH_SPACE};
                    row = 0;
                    col = 0;
                end
                default:
                    ;
            endcase
            r.row = 5'(row);
            r.col = 7'(col);
            awaited.push_back(r);
        endfunction

        function void check_result(console_result_t got);
            console_result_t want;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: row %0d col %0d cell %h",
                             got.row, got.col, got.cell_data);
                return;
            end
            want = awaited.pop_front();
            if (got.row !== want.row || got.col !== want.col
                || got.cell_data !== want.cell_data)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: expected row %0d col %0d cell %h, got row %0d col %0d cell %h",
                             want.row, want.col, want.cell_data,
                             got.row, got.col, got.cell_data);
            end
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic [1:0]  req_type     = RQ_PUT;
    logic [7:0]  char_code    = 8'h00;
    logic [10:0] cell_address = 11'd0;
    logic        out_stall    = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = 3'd0;
    logic [31:0] pwdata       = 32'd0;
    logic        in_stall;
    logic        out_valid;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [15:0] cell_value;
    logic [31:0] prdata;
    logic        pready;

    console_scoreboard sb;
    bit                calm          = 1'b0;
    int                results_seen  = 0;
    int                hold_left     = 0;
    int                counted_items = 0;

    text_console_char_writer #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .char_code    (char_code),
        .cell_address (cell_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .cell_value   (cell_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock of 10 ns.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check every transfer, stall at random, and hold off once for a long stretch.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result({cursor_row, cursor_col, cell_value});
            results_seen++;
            if (results_seen == HOLD_OFF_AT)
                hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 11);
    end

    // Offer one request, with random idle cycles ahead of it, and note it once transferred.
    task automatic send_request(input logic [1:0] req, input logic [7:0] ch,
                                input logic [10:0] addr);
        while (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        char_code    <= ch;
        cell_address <= addr;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_request(req, ch, addr);
        if (req != RQ_UNUSED && !(req == RQ_PUT && ch == CH_NUL))
            counted_items++;
    endtask

    // Register write: setup phase, then access phase. Upper data bits carry noise.
    task automatic write_colour(input logic idx, input logic [3:0] value);
        logic [31:0] word;
        word    = ($urandom() & 32'hFFFF_FFF0) | {28'd0, value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_colour(idx, word);
        @(posedge clk);
    endtask

    // Let the block drain, then change both colours.
    task automatic settle_then_set(input logic [3:0] fore, input logic [3:0] back);
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_colour(REG_FORE, fore);
        write_colour(REG_BACK, back);
    endtask

    // Random traffic, mostly lines of text with control bytes mixed in.
    task automatic random_phase(input int goal);
        int          stop_at;
        int          pick;
        int          len;
        int          here;
        logic [7:0]  ch;
        logic [10:0] addr;
        stop_at = counted_items + goal;
        while (counted_items < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
            begin
                len = ($urandom_range(7) == 0) ? $urandom_range(100) : $urandom_range(12);
                for (int k = 0; k < len; k++)
                begin
                    case ($urandom_range(19))
                        0:       ch = CH_TAB;
                        1:       ch = CH_BS;
                        2, 3:    ch = 8'($urandom());
                        default: ch = 8'($urandom_range(8'h7E, 8'h20));
                    endcase
                    send_request(RQ_PUT, ch, 11'($urandom()));
                end
                case ($urandom_range(19))
                    0, 1, 2:
                        ;
                    3, 4:
                        send_request(RQ_PUT, CH_CR, 11'($urandom()));
                    5, 6, 7:
                    begin
                        send_request(RQ_PUT, CH_CR, 11'($urandom()));
                        send_request(RQ_PUT, CH_LF, 11'($urandom()));
                    end
                    default:
                        send_request(RQ_PUT, CH_LF, 11'($urandom()));
                endcase
            end
            else if (pick < 78)
            begin
                // Reads, mostly just behind the cursor where the last writes landed.
                repeat ($urandom_range(4, 1))
                begin
                    case ($urandom_range(7))
                        0:
                            addr = 11'($urandom());
                        1, 2:
                            addr = 11'($urandom_range(CELLS - 1));
                        default:
                        begin
                            here = int'(sb.row) * COLUMNS + int'(sb.col)
                                   - int'($urandom_range(3));
                            if (here < 0)
                                here = 0;
                            addr = 11'(here);
                        end
                    endcase
                    send_request(RQ_READ, 8'($urandom()), addr);
                end
            end
            else if (pick < 86)
            begin
                repeat ($urandom_range(6, 1))
                    send_request(RQ_PUT, CH_BS, 11'($urandom()));
            end
            else if (pick < 88)
                send_request(RQ_CLEAR, 8'($urandom()), 11'($urandom()));
            else
                send_request(2'($urandom()), 8'($urandom()), 11'($urandom()));
        end
    endtask

    // Main sequence: reset, directed cases, then random phases over several colour settings.
    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with the colours as they come out of reset.
        send_request(RQ_PUT, CH_BS, 11'd0);
        send_request(RQ_READ, 8'h00, 11'd0);
        send_request(RQ_PUT, 8'h41, 11'd0);
        send_request(RQ_PUT, 8'hFF, 11'h7FF);
        send_request(RQ_PUT, 8'h01, 11'd0);
        send_request(RQ_PUT, CH_NUL, 11'd0);
        send_request(RQ_READ, 8'h00, 11'd1);
        send_request(RQ_PUT, CH_BS, 11'd0);
        send_request(RQ_READ, 8'h00, 11'd2);
        send_request(RQ_PUT, CH_TAB, 11'd0);
        send_request(RQ_PUT, CH_CR, 11'd0);
        send_request(RQ_PUT, CH_LF, 11'd0);
        send_request(RQ_PUT, CH_BS, 11'd0);
        send_request(RQ_READ, 8'h00, 11'(COLUMNS - 1));
        send_request(RQ_PUT, 8'h7F, 11'd0);
        send_request(RQ_READ, 8'h00, 11'(CELLS - 1));
        send_request(RQ_READ, 8'h00, 11'(CELLS));
        send_request(RQ_READ, 8'hFF, 11'h7FF);
        send_request(RQ_UNUSED, 8'hFF, 11'h7FF);
        send_request(RQ_CLEAR, 8'h00, 11'd0);
        send_request(RQ_READ, 8'h00, 11'(CELLS - 1));
        send_request(RQ_READ, 8'h00, 11'd0);

        // First random phase runs without any idling on either side.
        settle_then_set(4'h0, 4'h0);
        calm = 1'b1;
        random_phase(ITEMS_PER_PHASE);
        calm = 1'b0;

        settle_then_set(4'hF, 4'hF);
        random_phase(ITEMS_PER_PHASE);

        settle_then_set(4'($urandom()), 4'($urandom()));
        random_phase(ITEMS_PER_PHASE);

        settle_then_set(4'($urandom()), 4'($urandom()));
        random_phase(ITEMS_PER_PHASE);

        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog, set well above the slowest legal run.
    initial
    begin
        #60_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== text_console_char_writer.f =====
sv/tcw_pkg.sv
sv/tcw_seq.sv
sv/tcw_dp.sv
sv/text_console_char_writer.sv
sv/tcw_check.sv
verif/testbench.sv
